### hw/rtl/nkls_pkg.sv
// nkls_pkg: shared constants, register indexes and the cell link type
// for the nearest-k light selector. No dependencies.

package nkls_pkg;

    // cache size and the widths that follow from it
    localparam int CACHE_DEPTH = 8;
    localparam int IDX_W       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(CACHE_DEPTH + 1);

    // fixed field widths
    localparam int ID_W    = 16;
    localparam int POS_W   = 16;
    localparam int MAG_W   = 16;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 34;
    localparam int SLOT_W  = 3;
    localparam int ECNT_W  = 4;
    localparam int CIDX_W  = 2;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_MODEL_X = 2'd0,
        REG_MODEL_Y = 2'd1,
        REG_MODEL_Z = 2'd2
    } cfg_reg_t;

    // what one cell shows its right-hand neighbour
    typedef struct packed {
        logic              valid;
        logic              farther;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dist_sq;
    } link_t;

endpackage

### hw/rtl/nkls_dist.sv
// nkls_dist: three-stage squared-distance pipeline (difference, square, sum).
// Depends on nkls_pkg.

module nkls_dist (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic        [nkls_pkg::ID_W-1:0]    in_id,
    input  logic signed [nkls_pkg::POS_W-1:0]   light_x,
    input  logic signed [nkls_pkg::POS_W-1:0]   light_y,
    input  logic signed [nkls_pkg::POS_W-1:0]   light_z,
    input  logic signed [nkls_pkg::POS_W-1:0]   model_x,
    input  logic signed [nkls_pkg::POS_W-1:0]   model_y,
    input  logic signed [nkls_pkg::POS_W-1:0]   model_z,
    output logic                                out_valid,
    output logic        [nkls_pkg::ID_W-1:0]    out_id,
    output logic        [nkls_pkg::DIST_W-1:0]  out_dist
);

    logic signed [nkls_pkg::POS_W:0]   dx;
    logic signed [nkls_pkg::POS_W:0]   dy;
    logic signed [nkls_pkg::POS_W:0]   dz;
    logic        [nkls_pkg::MAG_W-1:0] mx_next;
    logic        [nkls_pkg::MAG_W-1:0] my_next;
    logic        [nkls_pkg::MAG_W-1:0] mz_next;

    logic                              v1_reg;
    logic                              v2_reg;
    logic                              v3_reg;
    logic        [nkls_pkg::ID_W-1:0]  id1_reg;
    logic        [nkls_pkg::ID_W-1:0]  id2_reg;
    logic        [nkls_pkg::ID_W-1:0]  id3_reg;
    logic        [nkls_pkg::MAG_W-1:0] mx_reg;
    logic        [nkls_pkg::MAG_W-1:0] my_reg;
    logic        [nkls_pkg::MAG_W-1:0] mz_reg;
    logic        [nkls_pkg::SQ_W-1:0]  sx_reg;
    logic        [nkls_pkg::SQ_W-1:0]  sy_reg;
    logic        [nkls_pkg::SQ_W-1:0]  sz_reg;
    logic        [nkls_pkg::DIST_W-1:0] dist_reg;

    // per-axis difference and its magnitude (fits 16 bits unsigned)
    always_comb
    begin
        dx = 17'(light_x) - 17'(model_x);
        dy = 17'(light_y) - 17'(model_y);
        dz = 17'(light_z) - 17'(model_z);
        mx_next = dx[nkls_pkg::POS_W] ? nkls_pkg::MAG_W'(-dx) : nkls_pkg::MAG_W'(dx);
        my_next = dy[nkls_pkg::POS_W] ? nkls_pkg::MAG_W'(-dy) : nkls_pkg::MAG_W'(dy);
        mz_next = dz[nkls_pkg::POS_W] ? nkls_pkg::MAG_W'(-dz) : nkls_pkg::MAG_W'(dz);
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // datapath: magnitude, square, sum
    always_ff @(posedge clk)
    begin
        id1_reg  <= in_id;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mz_reg   <= mz_next;
        id2_reg  <= id1_reg;
        sx_reg   <= mx_reg * mx_reg;
        sy_reg   <= my_reg * my_reg;
        sz_reg   <= mz_reg * mz_reg;
        id3_reg  <= id2_reg;
        dist_reg <= nkls_pkg::DIST_W'(sx_reg) + nkls_pkg::DIST_W'(sy_reg)
                    + nkls_pkg::DIST_W'(sz_reg);
    end

    assign out_valid = v3_reg;
    assign out_id    = id3_reg;
    assign out_dist  = dist_reg;

endmodule

### hw/rtl/nkls_cell.sv
// nkls_cell: one slot of the sorted cache; compares against the candidate
// and either keeps, takes the candidate or takes its left neighbour. Uses nkls_pkg.

module nkls_cell (
    input  logic                               clk,
    input  logic                               upd,
    input  logic                               valid,
    input  logic [nkls_pkg::ID_W-1:0]          cand_id,
    input  logic [nkls_pkg::DIST_W-1:0]        cand_dist,
    input  nkls_pkg::link_t                    prev,
    output nkls_pkg::link_t                    link,
    output logic                               take
);

    logic [nkls_pkg::ID_W-1:0]   id_reg;
    logic [nkls_pkg::DIST_W-1:0] dist_reg;
    logic                        farther;

    // this entry is strictly farther than the candidate
    assign farther = valid && (cand_dist < dist_reg);

    // candidate lands here: first farther entry, or first free slot
    assign take = !prev.farther && (farther || (!valid && prev.valid));

    // entry update: shift from the left wins, then the candidate
    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            if (prev.farther)
            begin
                id_reg   <= prev.id;
                dist_reg <= prev.dist_sq;
            end
            else if (take)
            begin
                id_reg   <= cand_id;
                dist_reg <= cand_dist;
            end
        end
    end

    assign link.valid   = valid;
    assign link.farther = farther;
    assign link.id      = id_reg;
    assign link.dist_sq = dist_reg;

endmodule

### hw/rtl/nearest_k_light_selector_core.sv
// nearest_k_light_selector_core: top level; config registers, distance
// pipeline, row of cache cells and result register. Uses nkls_pkg, nkls_dist, nkls_cell.

// Takes one light item per clock (busy stays low) and gives its result on a
// one-cycle done strobe that cannot be held off: the distance pipeline
// registers the difference, the square and the sum, and the compare-and-shift
// across the row of cache cells, which updates all slots in the same cycle,
// feeds the result register, so each item sees the cache as left by the one
// before it. Model position registers are written with cfg_we; write them
// only when no item is in flight.

module nearest_k_light_selector_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [nkls_pkg::CIDX_W-1:0]    cfg_index,
    input  logic        [nkls_pkg::POS_W-1:0]     cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [nkls_pkg::ID_W-1:0]      light_id,
    input  logic signed [nkls_pkg::POS_W-1:0]     light_x,
    input  logic signed [nkls_pkg::POS_W-1:0]     light_y,
    input  logic signed [nkls_pkg::POS_W-1:0]     light_z,
    output logic                                  done,
    output logic                                  inserted,
    output logic        [nkls_pkg::SLOT_W-1:0]    slot,
    output logic        [nkls_pkg::ECNT_W-1:0]    entry_count,
    output logic                                  evicted,
    output logic        [nkls_pkg::ID_W-1:0]      evicted_id
);

    localparam int D = nkls_pkg::CACHE_DEPTH;

    logic signed [nkls_pkg::POS_W-1:0]  model_x_reg;
    logic signed [nkls_pkg::POS_W-1:0]  model_y_reg;
    logic signed [nkls_pkg::POS_W-1:0]  model_z_reg;

    logic                               cand_valid;
    logic        [nkls_pkg::ID_W-1:0]   cand_id;
    logic        [nkls_pkg::DIST_W-1:0] cand_dist;

    logic        [nkls_pkg::CNT_W-1:0]  count_reg;
    logic        [nkls_pkg::CNT_W-1:0]  count_next;

    nkls_pkg::link_t                    links [D];
    nkls_pkg::link_t                    prevs [D];
    logic        [D-1:0]                takes;

    logic                               full;
    logic                               ins;
    logic                               evict;
    logic        [nkls_pkg::IDX_W-1:0]  slot_idx;

    logic                               done_reg;
    logic                               ins_reg;
    logic        [nkls_pkg::IDX_W-1:0]  slot_reg;
    logic        [nkls_pkg::CNT_W-1:0]  ecnt_reg;
    logic                               evict_reg;
    logic        [nkls_pkg::ID_W-1:0]   evid_reg;

    // every cycle can take an item
    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_x_reg <= '0;
            model_y_reg <= '0;
            model_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nkls_pkg::REG_MODEL_X: model_x_reg <= cfg_data;
                nkls_pkg::REG_MODEL_Y: model_y_reg <= cfg_data;
                nkls_pkg::REG_MODEL_Z: model_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // squared distance
    nkls_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_id     (light_id),
        .light_x   (light_x),
        .light_y   (light_y),
        .light_z   (light_z),
        .model_x   (model_x_reg),
        .model_y   (model_y_reg),
        .model_z   (model_z_reg),
        .out_valid (cand_valid),
        .out_id    (cand_id),
        .out_dist  (cand_dist)
    );

    // row of cache cells; slot i is valid while i is below the count
    for (genvar i = 0; i < D; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign prevs[i] = '{valid: 1'b1, farther: 1'b0, id: '0, dist_sq: '0};
        end
        else
        begin : g_body
            assign prevs[i] = links[i-1];
        end

        nkls_cell u_cell (
            .clk       (clk),
            .upd       (cand_valid),
            .valid     (count_reg > nkls_pkg::CNT_W'(i)),
            .cand_id   (cand_id),
            .cand_dist (cand_dist),
            .prev      (prevs[i]),
            .link      (links[i]),
            .take      (takes[i])
        );
    end

    // outcome: eviction only when full and the last entry is farther
    assign full  = links[D-1].valid;
    assign evict = full && links[D-1].farther;
    assign ins   = !full || links[D-1].farther;

    // landing slot from the one-hot take flags
    always_comb
    begin
        slot_idx = '0;
        for (int i = 0; i < D; i++)
        begin
            if (takes[i])
            begin
                slot_idx = slot_idx | nkls_pkg::IDX_W'(i);
            end
        end
    end

    assign count_next = count_reg + nkls_pkg::CNT_W'(ins && !full);

    // count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cand_valid;
            if (cand_valid)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cand_valid)
        begin
            ins_reg   <= ins;
            slot_reg  <= ins ? slot_idx : '0;
            ecnt_reg  <= count_next;
            evict_reg <= evict;
            evid_reg  <= evict ? links[D-1].id : '0;
        end
    end

    assign done        = done_reg;
    assign inserted    = ins_reg;
    assign slot        = nkls_pkg::SLOT_W'(slot_reg);
    assign entry_count = nkls_pkg::ECNT_W'(ecnt_reg);
    assign evicted     = evict_reg;
    assign evicted_id  = evid_reg;

endmodule
